>>> hdl/gcb_pkg.sv
// ----------------------------------------------------------------------------
// gcb_pkg: shared types and constants of the graph cycle breaker
// Operation codes, sizes, FSM states and controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int NODES       = 8;
    localparam int NODE_W      = $clog2(NODES);
    localparam int NEXT_W      = $clog2(NODES + 1);
    localparam int DEPTH_W     = $clog2(NODES + 1);
    localparam int MAX_REPORTS = 21;
    localparam int CNT_W       = 5;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_REMOVE     = 3'd1;
    localparam logic [2:0] OP_REMOVE_ONE = 3'd2;
    localparam logic [2:0] OP_REMOVE_ALL = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ROOT,
        ST_WALK,
        ST_FOUND,
        ST_FINISH,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture request and execute edit/read
        logic clr_walk;  // start a new search
        logic root_step; // try current root
        logic walk_step; // one DFS step
        logic remove;    // remove found edge and report it
        logic finish;    // produce closing result
        logic out_done;  // result taken
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       search_op;
        logic       all_op;
        logic       roots_done;
        logic       stack_empty;
        logic       found;
        logic       tally_full;
    } stat_t;

endpackage

>>> hdl/gcb_ctrl.sv
// ----------------------------------------------------------------------------
// gcb_ctrl: sequencer of the graph cycle breaker
// Steps requests through load, depth-first search, edge removal and output.
// ----------------------------------------------------------------------------
module gcb_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic            out_fire,
    input  gcb_pkg::stat_t  stat,
    output gcb_pkg::cmd_t   cmd,
    output logic            in_ready,
    output logic            out_valid
);

    gcb_pkg::state_t state_reg, state_next;

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gcb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // decode next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            gcb_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = gcb_pkg::ST_START;
                end
            end
            // searches start a walk, edits and reads go straight to output
            gcb_pkg::ST_START: begin
                if (stat.search_op) begin
                    cmd.clr_walk = 1'b1;
                    state_next   = gcb_pkg::ST_ROOT;
                end else begin
                    state_next = gcb_pkg::ST_OUT;
                end
            end
            gcb_pkg::ST_ROOT: begin
                if (stat.roots_done) begin
                    state_next = gcb_pkg::ST_FINISH;
                end else begin
                    cmd.root_step = 1'b1;
                    state_next    = gcb_pkg::ST_WALK;
                end
            end
            gcb_pkg::ST_WALK: begin
                if (stat.found) begin
                    state_next = gcb_pkg::ST_FOUND;
                end else if (stat.stack_empty) begin
                    state_next = gcb_pkg::ST_ROOT;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            gcb_pkg::ST_FOUND: begin
                cmd.remove = 1'b1;
                state_next = gcb_pkg::ST_OUT;
            end
            gcb_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = gcb_pkg::ST_OUT;
            end
            gcb_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_fire) begin
                    cmd.out_done = 1'b1;
                    if (stat.found && stat.all_op && !stat.tally_full) begin
                        // continue remove-all with a fresh search
                        cmd.clr_walk = 1'b1;
                        state_next   = gcb_pkg::ST_ROOT;
                    end else if (stat.found && stat.all_op) begin
                        state_next = gcb_pkg::ST_FINISH;
                    end else begin
                        state_next = gcb_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = gcb_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> hdl/gcb_dp.sv
// ----------------------------------------------------------------------------
// gcb_dp: datapath of the graph cycle breaker
// Adjacency matrix, visited marks, DFS stack and the output result register.
// ----------------------------------------------------------------------------
module gcb_dp (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gcb_pkg::cmd_t              cmd,
    input  logic [2:0]                 in_op,
    input  logic [2:0]                 in_a,
    input  logic [2:0]                 in_b,
    output gcb_pkg::stat_t             stat,
    output logic [23:0]                out_data,
    output logic                       out_last
);

    localparam int N  = gcb_pkg::NODES;
    localparam int NW = gcb_pkg::NODE_W;

    logic [N-1:0]                 adj_reg [N];
    logic [N-1:0]                 vis_reg;
    logic [NW-1:0]                stk_node_reg [N];
    logic [gcb_pkg::NEXT_W-1:0]   stk_next_reg [N];
    logic [gcb_pkg::DEPTH_W-1:0]  depth_reg;
    logic [gcb_pkg::NEXT_W-1:0]   root_reg;
    logic [gcb_pkg::CNT_W-1:0]    tally_reg;
    logic [2:0]                   op_reg;
    logic                         found_reg;
    logic                         pending_reg;  // search not yet run for this request
    logic [NW-1:0]                fu_reg, fv_reg;
    logic                         o_er_reg, o_last_reg;
    logic [2:0]                   o_u_reg, o_v_reg;
    logic [4:0]                   o_cnt_reg;
    logic [7:0]                   o_row_reg;

    // top of stack view
    logic [NW-1:0]                top_idx, par_node, n_cur;
    logic [gcb_pkg::NEXT_W-1:0]   j_cur;
    logic [NW-1:0]                j_idx;
    logic                         j_end, adj_bit, vis_bit, is_parent;
    logic [N-1:0]                 read_row;
    logic                         a_ok, b_ok;

    assign top_idx   = NW'(depth_reg - 1'b1);
    assign n_cur     = stk_node_reg[top_idx];
    assign j_cur     = stk_next_reg[top_idx];
    assign j_end     = (j_cur >= gcb_pkg::NEXT_W'(N));
    assign j_idx     = j_cur[NW-1:0];
    assign adj_bit   = adj_reg[n_cur][j_idx];
    assign vis_bit   = vis_reg[j_idx];
    assign par_node  = stk_node_reg[NW'(depth_reg - 2'd2)];
    assign is_parent = (depth_reg > 1) && (par_node == j_idx);
    assign a_ok      = (32'(in_a) < N);
    assign b_ok      = (32'(in_b) < N);
    assign read_row  = a_ok ? adj_reg[in_a[NW-1:0]] : '0;

    assign stat.search_op   = pending_reg;
    assign stat.all_op      = (op_reg == gcb_pkg::OP_REMOVE_ALL);
    assign stat.roots_done  = (root_reg >= gcb_pkg::NEXT_W'(N));
    assign stat.stack_empty = (depth_reg == 0);
    assign stat.found       = found_reg;
    assign stat.tally_full  = (tally_reg >= gcb_pkg::CNT_W'(gcb_pkg::MAX_REPORTS));

    // advance matrix, walk and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < N; i++) adj_reg[i] <= '0;
            vis_reg     <= '0;
            depth_reg   <= '0;
            tally_reg   <= '0;
            root_reg    <= '0;
            found_reg   <= 1'b0;
            pending_reg <= 1'b0;
            op_reg      <= '0;
        end else begin
            if (cmd.load) begin
                op_reg      <= in_op;
                found_reg   <= 1'b0;
                tally_reg   <= '0;
                pending_reg <= (in_op == gcb_pkg::OP_REMOVE_ONE) ||
                               (in_op == gcb_pkg::OP_REMOVE_ALL);
                o_er_reg <= 1'b0; o_u_reg <= '0; o_v_reg <= '0; o_cnt_reg <= '0;
                o_row_reg  <= '0;
                o_last_reg <= 1'b1;
                if (in_op == gcb_pkg::OP_READ) o_row_reg <= 8'(read_row);
                if ((in_op == gcb_pkg::OP_INSERT || in_op == gcb_pkg::OP_REMOVE)
                    && a_ok && b_ok) begin
                    adj_reg[in_a[NW-1:0]][in_b[NW-1:0]] <= (in_op == gcb_pkg::OP_INSERT);
                    adj_reg[in_b[NW-1:0]][in_a[NW-1:0]] <= (in_op == gcb_pkg::OP_INSERT);
                end
            end
            if (cmd.clr_walk) begin
                vis_reg     <= '0;
                depth_reg   <= '0;
                root_reg    <= '0;
                found_reg   <= 1'b0;
                pending_reg <= 1'b0;
            end
            // start a tree at the current root if unvisited
            if (cmd.root_step) begin
                root_reg <= root_reg + 1'b1;
                if (!vis_reg[root_reg[NW-1:0]]) begin
                    vis_reg[root_reg[NW-1:0]] <= 1'b1;
                    stk_node_reg[0] <= root_reg[NW-1:0];
                    stk_next_reg[0] <= '0;
                    depth_reg       <= gcb_pkg::DEPTH_W'(1);
                end
            end
            // one neighbor of the stack top per cycle
            if (cmd.walk_step) begin
                if (j_end) begin
                    depth_reg <= depth_reg - 1'b1;
                end else begin
                    stk_next_reg[top_idx] <= j_cur + 1'b1;
                    if (adj_bit) begin
                        if (!vis_bit) begin
                            if (depth_reg < gcb_pkg::DEPTH_W'(N)) begin
                                vis_reg[j_idx] <= 1'b1;
                                stk_node_reg[NW'(depth_reg)] <= j_idx;
                                stk_next_reg[NW'(depth_reg)] <= '0;
                                depth_reg <= depth_reg + 1'b1;
                            end
                        end else if (!is_parent) begin
                            found_reg <= 1'b1;
                            fu_reg    <= n_cur;
                            fv_reg    <= j_idx;
                            depth_reg <= '0;
                        end
                    end
                end
            end
            // drop the found edge and report it
            if (cmd.remove) begin
                adj_reg[fu_reg][fv_reg] <= 1'b0;
                adj_reg[fv_reg][fu_reg] <= 1'b0;
                tally_reg  <= tally_reg + 1'b1;
                o_er_reg   <= 1'b1;
                o_u_reg    <= 3'(fu_reg);
                o_v_reg    <= 3'(fv_reg);
                o_row_reg  <= '0;
                o_cnt_reg  <= (op_reg == gcb_pkg::OP_REMOVE_ONE) ? 5'd1 : 5'd0;
                o_last_reg <= (op_reg == gcb_pkg::OP_REMOVE_ONE);
            end
            if (cmd.finish) begin
                found_reg  <= 1'b0;
                o_er_reg   <= 1'b0;
                o_u_reg    <= '0;
                o_v_reg    <= '0;
                o_row_reg  <= '0;
                o_cnt_reg  <= 5'(tally_reg);
                o_last_reg <= 1'b1;
            end
        end
    end

    // bit0 edge_removed, 3:1 removed_u, 6:4 removed_v, 11:7 removed_count,
    // 19:12 row_bits, zero pad
    assign out_data = {4'd0, o_row_reg, o_cnt_reg, o_v_reg, o_u_reg, o_er_reg};
    assign out_last = o_last_reg;

endmodule

>>> hdl/graph_cycle_breaker_core.sv
// ----------------------------------------------------------------------------
// graph_cycle_breaker_core: undirected graph with DFS cycle breaking
// Sequence: an edit or read passes through the start state to the output state;
// a search visits one neighbor a cycle, and the search is repeated per removed
// edge.
// Throughput: one request at a time; next request after the last result.
// Reset: synchronous active-low aresetn clears the graph and the sequencer.
// ----------------------------------------------------------------------------
module graph_cycle_breaker_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // operation[2:0], node_a[5:3], node_b[8:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // edge_removed, removed_u, removed_v,
                                   // removed_count, row_bits
    output logic        m_tlast
);

    gcb_pkg::cmd_t  cmd;
    gcb_pkg::stat_t stat;
    logic           unused_pad;

    assign unused_pad = ^s_tdata[15:9];

    gcb_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_tvalid && s_tready),
        .out_fire  (m_tvalid && m_tready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    gcb_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .in_op    (s_tdata[2:0]),
        .in_a     (s_tdata[5:3]),
        .in_b     (s_tdata[8:6]),
        .stat     (stat),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule

>>> hdl/gcb_checker.sv
// ----------------------------------------------------------------------------
// gcb_checker: port-level checks of the graph cycle breaker
// Watches handshakes and result fields at the top level.
// ----------------------------------------------------------------------------
module gcb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // no new request while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // edge reports never carry a row
    a_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[19:12] == 8'd0)
        else $error("row on edge report");

    // an accepted request closes the input until its results are out
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after request");

    // results that report no edge end their request
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tlast) else $error("missing last");

endmodule

bind graph_cycle_breaker_core gcb_checker u_gcb_checker (.*);
